[hdl/ilid_pkg.sv]
// ----------------------------------------------------------------------------
// ilid_pkg
// Shared command codes, status codes and the shift control word that the
// top level drives into every list cell.
// ----------------------------------------------------------------------------
package ilid_pkg;

    localparam int WORD_W    = 32;
    localparam int CMD_W     = 3;
    localparam int POS_W     = 8;
    localparam int STATUS_W  = 2;
    localparam int LEN_OUT_W = 7;
    localparam int MAX_LEN_W = 13;
    localparam int DEF_CAPACITY = 64;

    localparam logic [CMD_W-1:0] CMD_HEAD   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TAIL   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic                 ins;
        logic                 del;
        logic [MAX_LEN_W-1:0] pos;
        t_word                word;
    } t_shift_ctl;

endpackage

[hdl/ilid_cell.sv]
// ----------------------------------------------------------------------------
// ilid_cell
// One list slot. Takes the left neighbor's word on insert past the position,
// the right one's on delete at or past it, the new word at it, else holds.
// ----------------------------------------------------------------------------
module ilid_cell
    import ilid_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic       i_clk,
    input  t_shift_ctl i_ctl,
    input  t_word      i_left_word,
    input  t_word      i_right_word,
    output t_word      o_word,
    output t_word      o_read_word
);

    localparam logic [MAX_LEN_W-1:0] C_IDX = MAX_LEN_W'(IDX);

    t_word r_word;
    t_word n_word;

    always_comb begin
        priority if (i_ctl.ins && i_ctl.pos == C_IDX) begin
            n_word = i_ctl.word;
        end else if (i_ctl.ins && i_ctl.pos < C_IDX) begin
            n_word = i_left_word;
        end else if (i_ctl.del && i_ctl.pos <= C_IDX) begin
            n_word = i_right_word;
        end else begin
            n_word = r_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word      = r_word;
    assign o_read_word = (i_ctl.pos == C_IDX) ? r_word : '0;

endmodule

[hdl/indexed_list_insert_delete_unit.sv]
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_unit
// Ordered list of up to CAPACITY signed words kept in a row of cells. Each
// command is add at head or tail, insert, delete or read: an insert or
// delete moves the words from the position on by one place at the same
// edge, and a read selects the addressed cell through an OR across the row.
// The result word sits in an output register, so a new command is taken every
// cycle the output is free or being taken. Cells are not cleared at reset;
// only length and output valid reset, and no clearing pass is needed.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_unit
    import ilid_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [CMD_W-1:0]        i_cmd,
    input  logic signed [POS_W-1:0] i_position,
    input  logic signed [WORD_W-1:0] i_word_in,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [STATUS_W-1:0]     o_status,
    output logic signed [WORD_W-1:0] o_read_word,
    output logic [LEN_OUT_W-1:0]    o_length
);

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = (LW > POS_W - 1) ? LW : POS_W - 1;

    logic [LW-1:0]          r_len;
    logic [LW-1:0]          n_len;
    logic                   r_valid;
    logic [STATUS_W-1:0]    r_status;
    t_word                  r_read_word;
    logic [LEN_OUT_W-1:0]   r_length;

    logic                   accept;
    logic                   neg;
    logic [CW-1:0]          pos_c;
    logic [CW-1:0]          len_c;
    logic                   full;
    logic [STATUS_W-1:0]    status;
    logic                   do_ins;
    logic                   do_del;
    logic                   do_read;
    logic [LW-1:0]          op_pos;
    t_word                  read_or;
    t_word                  read_word;
    t_shift_ctl             ctl;

    t_word cell_word [CAPACITY];
    t_word cell_rd   [CAPACITY];

    assign accept = i_valid && o_ready;
    assign neg    = i_position[POS_W-1];
    assign pos_c  = CW'(i_position[POS_W-2:0]);
    assign len_c  = CW'(r_len);
    assign full   = (r_len == LW'(CAPACITY));

    always_comb begin
        status  = ST_DONE;
        do_ins  = 1'b0;
        do_del  = 1'b0;
        do_read = 1'b0;
        op_pos  = pos_c[LW-1:0];
        unique case (i_cmd)
            CMD_HEAD: begin
                op_pos = '0;
                if (full) status = ST_FULL;
                else      do_ins = 1'b1;
            end
            CMD_TAIL: begin
                op_pos = r_len;
                if (full) status = ST_FULL;
                else      do_ins = 1'b1;
            end
            CMD_INSERT: begin
                if (neg || pos_c > len_c) status = ST_RANGE;
                else if (full)            status = ST_FULL;
                else                      do_ins = 1'b1;
            end
            CMD_DELETE: begin
                if (neg || pos_c >= len_c) status = ST_RANGE;
                else                       do_del = 1'b1;
            end
            CMD_READ: begin
                if (neg || pos_c >= len_c) status = ST_RANGE;
                else                       do_read = 1'b1;
            end
            default: begin
                status = ST_DONE;
            end
        endcase
    end

    assign ctl.ins  = accept && do_ins;
    assign ctl.del  = accept && do_del;
    assign ctl.pos  = MAX_LEN_W'(op_pos);
    assign ctl.word = i_word_in;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_word left_word;
            t_word right_word;
            if (g == 0) begin : g_first
                assign left_word = '0;
            end else begin : g_mid_l
                assign left_word = cell_word[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign right_word = cell_word[g];
            end else begin : g_mid_r
                assign right_word = cell_word[g+1];
            end
            ilid_cell #(
                .IDX(g)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (ctl),
                .i_left_word  (left_word),
                .i_right_word (right_word),
                .o_word       (cell_word[g]),
                .o_read_word  (cell_rd[g])
            );
        end
    endgenerate

    always_comb begin
        read_or = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            read_or = read_or | cell_rd[k];
        end
    end

    always_comb begin
        priority if (do_read)              read_word = read_or;
        else if (i_cmd == CMD_READ)        read_word = '1;
        else                               read_word = '0;
    end

    always_comb begin
        priority if (do_ins) n_len = r_len + LW'(1);
        else if (do_del)     n_len = r_len - LW'(1);
        else                 n_len = r_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_len   <= n_len;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= status;
            r_read_word <= read_word;
            r_length    <= LEN_OUT_W'(n_len);
        end
    end

    assign o_ready     = !r_valid || i_ready;
    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_read_word = r_read_word;
    assign o_length    = r_length;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(CAPACITY))
        else $error("list length above capacity");

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_length == LEN_OUT_W'(CAPACITY))
        else $error("full status with list not full");

    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.ins |=> r_len == $past(r_len) + LW'(1))
        else $error("insert did not grow list");

    a_del_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.del |=> r_len == $past(r_len) - LW'(1))
        else $error("delete did not shrink list");

endmodule
